@@ rtl/htsd_pkg.sv @@
// Shared constants, types and helpers for the Huffman table stream decoder.
// No dependencies; imported by every module of the block.
package htsd_pkg;

	localparam int SYMBOL_COUNT = 256;
	localparam int MAX_CODE_LEN = 16;

	localparam int MODE_W = 2;
	localparam int SYM_W  = 8;
	localparam int LEN_W  = 5;
	localparam int CODE_W = 16;
	localparam int BYTE_W = 8;
	localparam int PAD_W  = 3;

	localparam int SYM_LSB  = 0;
	localparam int LEN_LSB  = SYM_LSB + SYM_W;
	localparam int CODE_LSB = LEN_LSB + LEN_W;
	localparam int BYTE_LSB = CODE_LSB + CODE_W;
	localparam int IN_FIELDS_W = BYTE_LSB + BYTE_W;
	localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = SYM_W;

	localparam int LANES  = 8;
	localparam int LANE_W = $clog2(LANES);
	localparam int ROWS   = (SYMBOL_COUNT + LANES - 1) / LANES;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int NV     = ROWS * LANES;
	localparam int NV_W   = ROW_W + LANE_W;

	localparam int PC_W   = MAX_CODE_LEN + 1;
	localparam int PL_W   = $clog2(MAX_CODE_LEN + 2);
	localparam int CMP_W  = (PC_W > CODE_W) ? PC_W : CODE_W;
	localparam int LCMP_W = (PL_W > LEN_W) ? PL_W : LEN_W;
	localparam int ENT_W  = LEN_W + CODE_W;

	typedef enum logic [MODE_W-1:0] {
		MODE_WRITE  = 2'd0,
		MODE_HEADER = 2'd1,
		MODE_DATA   = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef struct packed {
		logic accept;
		logic shift;
		logic scan;
		logic emit;
		logic next;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic miss;
		logic over_len;
		logic hold_busy;
		logic stuck;
		logic bit_last;
	} status_t;

	function automatic logic [CODE_W-1:0] code_mask(input logic [LEN_W-1:0] len);
		logic [CODE_W:0] one_hot;
		if (len >= LEN_W'(CODE_W)) begin
			return '1;
		end
		one_hot = (CODE_W+1)'(1) << len;
		return CODE_W'(one_hot - (CODE_W+1)'(1));
	endfunction

endpackage

@@ rtl/htsd_ctrl.sv @@
// Sequencer of the Huffman table stream decoder: walks each data byte bit by bit.
// Depends on htsd_pkg; drives htsd_datapath through cmd_t and reads status_t.
module htsd_ctrl
	import htsd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [MODE_W-1:0] s_tuser,
	input  status_t           sts,
	output cmd_t              cmd
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SHIFT  = 6'b000010,
		ST_SCAN   = 6'b000100,
		ST_EMIT   = 6'b001000,
		ST_NEXT   = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
				if (s_tvalid && mode_t'(s_tuser) == MODE_DATA) begin
					state_d = sts.stuck ? ST_FINISH : ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				state_d   = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					state_d = ST_EMIT;
				end else if (sts.miss) begin
					state_d = sts.over_len ? ST_EMIT : ST_NEXT;
				end
			end
			ST_EMIT: begin
				if (!sts.hold_busy) begin
					cmd.emit = 1'b1;
					state_d  = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (sts.bit_last || sts.stuck) begin
					state_d = ST_FINISH;
				end else begin
					cmd.next = 1'b1;
					state_d  = ST_SHIFT;
				end
			end
			ST_FINISH: begin
				if (!sts.hold_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/htsd_datapath.sv @@
// Datapath of the Huffman table stream decoder: code table, partial code,
// row-wise table match, result hold stage and output register. Uses htsd_pkg.
module htsd_datapath
	import htsd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output status_t                sts,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic [MODE_W-1:0]      s_tuser,
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tuser,
	output logic                   m_tlast
);

	logic [ENT_W-1:0]  tab_mem [ROWS][LANES];
	logic [NV-1:0]     valid_q;

	logic [SYM_W-1:0]  in_symbol;
	logic [LEN_W-1:0]  in_len;
	logic [CODE_W-1:0] in_code;
	logic [BYTE_W-1:0] in_byte;
	mode_t             in_mode;
	logic              in_range;
	logic [ROW_W-1:0]  wr_row;
	logic [LANE_W-1:0] wr_lane;
	logic [NV_W-1:0]   wr_idx;

	logic [PC_W-1:0]   part_code_q;
	logic [PL_W-1:0]   part_len_q;
	logic [PAD_W-1:0]  pad_q;
	logic              stuck_q;
	logic [BYTE_W-1:0] byte_q;
	logic              is_last_q;
	logic [2:0]        bit_idx_q;

	logic [ROW_W-1:0]  row_q;
	logic              rd_valid_s1;
	logic [ROW_W-1:0]  row_s1;
	logic [ENT_W-1:0]  rd_row_s1 [LANES];
	logic [LANES-1:0]  vld_s1;

	logic [LANES-1:0]  lane_hit;
	logic              any_hit;
	logic [LANE_W-1:0] hit_lane;
	logic [SYM_W-1:0]  hit_sym;

	logic [SYM_W-1:0]  res_sym_q;
	logic              res_err_q;
	logic              hold_valid_q;
	logic [SYM_W-1:0]  hold_sym_q;
	logic              hold_err_q;

	logic              out_valid_q;
	logic [SYM_W-1:0]  out_sym_q;
	logic              out_err_q;
	logic              out_last_q;
	logic              push;
	logic              push_last;
	logic [2:0]        last_idx;

	assign in_symbol = s_tdata[SYM_LSB +: SYM_W];
	assign in_len    = s_tdata[LEN_LSB +: LEN_W];
	assign in_code   = s_tdata[CODE_LSB +: CODE_W];
	assign in_byte   = s_tdata[BYTE_LSB +: BYTE_W];
	assign in_mode   = mode_t'(s_tuser);
	assign in_range  = (9'(in_symbol) < 9'(SYMBOL_COUNT));
	assign wr_lane   = in_symbol[LANE_W-1:0];
	assign wr_row    = ROW_W'(in_symbol >> LANE_W);
	assign wr_idx    = {wr_row, wr_lane};

	always_comb begin
		logic [LEN_W-1:0]  e_len;
		logic [CODE_W-1:0] e_code;
		for (int l = 0; l < LANES; l++) begin
			e_len       = rd_row_s1[l][CODE_W +: LEN_W];
			e_code      = rd_row_s1[l][CODE_W-1:0];
			lane_hit[l] = vld_s1[l] && (LCMP_W'(e_len) == LCMP_W'(part_len_q)) &&
				(CMP_W'(e_code) == CMP_W'(part_code_q));
		end
	end

	always_comb begin
		hit_lane = '0;
		for (int l = LANES - 1; l >= 0; l--) begin
			if (lane_hit[l]) begin
				hit_lane = LANE_W'(l);
			end
		end
	end

	assign any_hit  = |lane_hit;
	assign hit_sym  = SYM_W'({row_s1, hit_lane});
	assign last_idx = is_last_q ? 3'(3'd7 - pad_q) : 3'd7;

	assign push      = (cmd.emit || cmd.finish) && hold_valid_q;
	assign push_last = cmd.finish;

	assign sts.hit       = rd_valid_s1 && any_hit;
	assign sts.miss      = rd_valid_s1 && !any_hit && (row_s1 == ROW_W'(ROWS - 1));
	assign sts.over_len  = (part_len_q > PL_W'(MAX_CODE_LEN));
	assign sts.hold_busy = hold_valid_q && out_valid_q && !m_tready;
	assign sts.stuck     = stuck_q;
	assign sts.bit_last  = (bit_idx_q == last_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			part_code_q  <= '0;
			part_len_q   <= '0;
			pad_q        <= '0;
			stuck_q      <= 1'b0;
			bit_idx_q    <= '0;
			row_q        <= '0;
			rd_valid_s1  <= 1'b0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.scan;
			out_valid_q <= push || (out_valid_q && !m_tready);
			if (cmd.accept) begin
				unique case (in_mode)
					MODE_WRITE: begin
						if (in_range) begin
							valid_q[wr_idx] <= (in_len != '0);
						end
					end
					MODE_HEADER: begin
						pad_q       <= (in_byte > BYTE_W'(7)) ? 3'd7 : PAD_W'(in_byte);
						part_code_q <= '0;
						part_len_q  <= '0;
						stuck_q     <= 1'b0;
					end
					MODE_DATA: begin
						bit_idx_q <= '0;
					end
					MODE_CLEAR: begin
						valid_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.shift) begin
				part_code_q <= {part_code_q[PC_W-2:0], byte_q[BYTE_W-1]};
				part_len_q  <= PL_W'(part_len_q + 1'b1);
				row_q       <= '0;
			end
			if (cmd.scan) begin
				row_q <= (row_q == ROW_W'(ROWS - 1)) ? '0 : ROW_W'(row_q + 1'b1);
			end
			if (cmd.emit) begin
				part_code_q  <= '0;
				part_len_q   <= '0;
				hold_valid_q <= 1'b1;
				if (res_err_q) begin
					stuck_q <= 1'b1;
				end
			end
			if (cmd.next) begin
				bit_idx_q <= 3'(bit_idx_q + 1'b1);
			end
			if (cmd.finish) begin
				hold_valid_q <= 1'b0;
				if (is_last_q) begin
					part_code_q <= '0;
					part_len_q  <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && in_mode == MODE_WRITE && in_range && in_len != '0) begin
			tab_mem[wr_row][wr_lane] <= {in_len, in_code & code_mask(in_len)};
		end
		rd_row_s1 <= tab_mem[row_q];
		vld_s1    <= valid_q[{row_q, LANE_W'(0)} +: LANES];
		row_s1    <= row_q;
		if (cmd.accept && in_mode == MODE_DATA) begin
			byte_q    <= in_byte;
			is_last_q <= s_tlast;
		end
		if (cmd.shift) begin
			byte_q <= {byte_q[BYTE_W-2:0], 1'b0};
		end
		if (cmd.scan && (sts.hit || sts.miss)) begin
			res_sym_q <= sts.hit ? hit_sym : '0;
			res_err_q <= !sts.hit;
		end
		if (cmd.emit) begin
			hold_sym_q <= res_sym_q;
			hold_err_q <= res_err_q;
		end
		if (push) begin
			out_sym_q  <= hold_sym_q;
			out_err_q  <= hold_err_q;
			out_last_q <= push_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_sym_q;
	assign m_tuser  = out_err_q;
	assign m_tlast  = out_last_q;

endmodule

@@ rtl/huffman_table_stream_decoder.sv @@
// Huffman table stream decoder, top level: sequencer plus datapath.
// Depends on htsd_pkg, htsd_ctrl and htsd_datapath.
//
// Table writes, table clears and stream headers are taken without leaving the
// idle state. A data byte is decoded one code bit at a time; for each bit the
// code table is read one row of eight entries per cycle from its single read
// port, stopping at the first matching row, so fewer rows are read when codes
// match early in the table. A result is held until the next one or the end of
// the byte decides whether it closes the run; the output register lets the
// block take the next item while the last result still waits.
module huffman_table_stream_decoder
	import htsd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// symbol[7:0], code_len[12:8], code_bits[28:13], byte_value[36:29], zero fill
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// mode[1:0]
	input  logic [MODE_W-1:0]      s_tuser,
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// decoded_symbol[7:0]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// code_error[0]
	output logic                   m_tuser,
	output logic                   m_tlast
);

	cmd_t    cmd;
	status_t sts;

	htsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	htsd_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

@@ rtl/htsd_checker.sv @@
// Port-level checks for huffman_table_stream_decoder, attached by bind.
// Depends on htsd_pkg.
module htsd_checker
	import htsd_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [IN_TDATA_W-1:0]  s_tdata,
	input logic [MODE_W-1:0]      s_tuser,
	input logic                   s_tlast,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tuser,
	input logic                   m_tlast
);

	a_err_symbol_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("error transfer carries a nonzero symbol");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
			$stable(m_tlast))
		else $error("stalled output transfer changed");

	a_data_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == MODE_DATA |=> !s_tready)
		else $error("ready stayed high after a data byte transfer");

	a_ctrl_single: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != MODE_DATA |=> s_tready)
		else $error("ready dropped after a table or header transfer");

	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared while the decoder was idle");

endmodule

bind huffman_table_stream_decoder htsd_checker u_htsd_checker (.*);

@@ tb/sv/huffman_table_stream_decoder_tb.sv @@
// Self-checking testbench for huffman_table_stream_decoder: directed table, then random
// code tables and packed streams, scored against an in-bench bit-serial decoder model.
// Depends on htsd_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module huffman_table_stream_decoder_tb;
	import htsd_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_CYCLES = 400;

	typedef struct packed {
		mode_t                 mode;
		logic [SYM_W-1:0]      sym;
		logic [LEN_W-1:0]      len;
		logic [CODE_W-1:0]     bits;
		logic [BYTE_W-1:0]     byte_v;
		logic                  last;
	} item_t;

	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic             err;
		logic             last;
	} symbol_out_t;

	typedef struct {
		item_t            it;
		int               n_out;
		logic [SYM_W-1:0] sym;
		logic             err;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic [MODE_W-1:0]      s_tuser = '0;
	logic                   s_tlast = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;

	int gap_pct = 0;
	int stall_pct = 0;
	int items_sent = 0;
	int fail_count = 0;
	int cycle_count = 0;

	symbol_out_t pending_symbols[$];
	symbol_out_t step_symbols[$];
	stim_row_t   directed_rows[$];

	bit                code_valid[SYMBOL_COUNT];
	logic [LEN_W-1:0]  code_len_tbl[SYMBOL_COUNT];
	logic [CODE_W-1:0] code_bits_tbl[SYMBOL_COUNT];
	logic [31:0]       shift_code = '0;
	int                shift_len = 0;
	int                pad_bits = 0;
	bit                stuck = 1'b0;

	huffman_table_stream_decoder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic log_mismatch(input string msg);
		if (fail_count < 10) begin
			$display("%0t: %s", $realtime, msg);
		end
		fail_count++;
	endtask

	always @(posedge clk) begin
		symbol_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_symbols.size() == 0) begin
				log_mismatch($sformatf("unexpected result: sym %0d err %0b last %0b",
					m_tdata, m_tuser, m_tlast));
			end else begin
				want = pending_symbols.pop_front();
				if (m_tdata !== want.sym || m_tuser !== want.err || m_tlast !== want.last) begin
					log_mismatch($sformatf(
						"result mismatch: expected sym %0d err %0b last %0b, got sym %0d err %0b last %0b",
						want.sym, want.err, want.last, m_tdata, m_tuser, m_tlast));
				end
			end
		end
	end

	// bit-serial decoder: results of one accepted item land in step_symbols
	task automatic decode_item(input item_t it);
		int               nbits;
		int               hit;
		logic [16:0]      msk;
		symbol_out_t      r;
		step_symbols.delete();
		case (it.mode)
			MODE_CLEAR: begin
				foreach (code_valid[s]) code_valid[s] = 1'b0;
			end
			MODE_WRITE: begin
				if (it.len == '0) begin
					code_valid[it.sym] = 1'b0;
				end else begin
					msk = (17'd1 << it.len) - 17'd1;
					code_valid[it.sym] = 1'b1;
					code_len_tbl[it.sym] = it.len;
					code_bits_tbl[it.sym] = it.bits & msk[CODE_W-1:0];
				end
			end
			MODE_HEADER: begin
				pad_bits = (it.byte_v > 8'd7) ? 7 : int'(it.byte_v);
				shift_code = '0;
				shift_len = 0;
				stuck = 1'b0;
			end
			default: begin
				nbits = it.last ? 8 - pad_bits : 8;
				for (int i = 0; i < nbits && !stuck; i++) begin
					shift_code = {shift_code[30:0], it.byte_v[7-i]};
					shift_len++;
					hit = -1;
					for (int s = 0; s < SYMBOL_COUNT && hit < 0; s++) begin
						if (code_valid[s] && int'(code_len_tbl[s]) == shift_len &&
							{16'd0, code_bits_tbl[s]} == shift_code) begin
							hit = s;
						end
					end
					if (hit >= 0) begin
						r = '{sym: SYM_W'(hit), err: 1'b0, last: 1'b0};
						step_symbols.insert(step_symbols.size(), r);
						shift_code = '0;
						shift_len = 0;
					end else if (shift_len > MAX_CODE_LEN) begin
						r = '{sym: '0, err: 1'b1, last: 1'b0};
						step_symbols.insert(step_symbols.size(), r);
						shift_code = '0;
						shift_len = 0;
						stuck = 1'b1;
					end
				end
				if (it.last) begin
					shift_code = '0;
					shift_len = 0;
				end
				if (step_symbols.size() > 0) begin
					step_symbols[step_symbols.size()-1].last = 1'b1;
				end
			end
		endcase
	endtask

	// n_out < 0: score against the decoder model, else against the typed-in result
	task automatic send_item(input item_t it, input int n_out = -1,
		input logic [SYM_W-1:0] sym_exp = '0, input logic err_exp = 1'b0);
		logic [IN_TDATA_W-1:0] word;
		symbol_out_t           r;
		word = '0;
		word[SYM_LSB +: SYM_W] = it.sym;
		word[LEN_LSB +: LEN_W] = it.len;
		word[CODE_LSB +: CODE_W] = it.bits;
		word[BYTE_LSB +: BYTE_W] = it.byte_v;
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		s_tuser <= it.mode;
		s_tlast <= it.last;
		do @(posedge clk); while (!s_tready);
		decode_item(it);
		if (n_out < 0) begin
			foreach (step_symbols[k]) pending_symbols.insert(pending_symbols.size(), step_symbols[k]);
		end else begin
			for (int k = 0; k < n_out; k++) begin
				r = '{sym: sym_exp, err: err_exp, last: (k == n_out - 1)};
				pending_symbols.insert(pending_symbols.size(), r);
			end
		end
		items_sent++;
	endtask

	function automatic item_t random_item(input mode_t m);
		item_t it;
		it.mode = m;
		it.sym = SYM_W'($urandom_range(255));
		it.len = LEN_W'($urandom_range(31));
		it.bits = CODE_W'($urandom_range(65535));
		it.byte_v = BYTE_W'($urandom_range(255));
		it.last = 1'($urandom_range(1));
		return it;
	endfunction

	function automatic stim_row_t mk(input mode_t m, input int sym, input int len, input int bits,
		input int bv, input bit last, input int n_out, input int sym_exp, input bit err_exp);
		stim_row_t row;
		row.it = '{mode: m, sym: SYM_W'(sym), len: LEN_W'(len), bits: CODE_W'(bits),
			byte_v: BYTE_W'(bv), last: last};
		row.n_out = n_out;
		row.sym = SYM_W'(sym_exp);
		row.err = err_exp;
		return row;
	endfunction

	// complete prefix code over random symbols, built by splitting leaves
	task automatic load_code_table();
		logic [CODE_W-1:0] leaf_code[$];
		int                leaf_len[$];
		logic [SYM_W-1:0]  syms[$];
		bit                taken[SYMBOL_COUNT];
		int                target;
		int                j;
		bit                chain;
		logic [CODE_W-1:0] c;
		logic [16:0]       msk;
		item_t             it;
		target = $urandom_range(2, 20);
		chain = ($urandom_range(2) == 0);
		leaf_code = '{16'd0, 16'd1};
		leaf_len = '{1, 1};
		while (leaf_code.size() < target) begin
			j = chain ? leaf_code.size() - 1 : $urandom_range(leaf_code.size() - 1);
			if (leaf_len[j] >= MAX_CODE_LEN) break;
			c = leaf_code[j];
			leaf_code[j] = c << 1;
			leaf_len[j] = leaf_len[j] + 1;
			leaf_code.insert(leaf_code.size(), (c << 1) | 16'd1);
			leaf_len.insert(leaf_len.size(), leaf_len[j]);
		end
		send_item(random_item(MODE_CLEAR));
		foreach (leaf_code[k]) begin
			it = random_item(MODE_WRITE);
			while (taken[it.sym]) it.sym = SYM_W'($urandom_range(255));
			taken[it.sym] = 1'b1;
			syms.insert(syms.size(), it.sym);
			it.len = LEN_W'(leaf_len[k]);
			msk = (17'd1 << leaf_len[k]) - 17'd1;
			it.bits = ($urandom_range(1) ? (it.bits & ~msk[CODE_W-1:0]) : '0) | leaf_code[k];
			send_item(it);
		end
		// drop one code now and then so that streams can run off the tree
		if ($urandom_range(3) == 0) begin
			it = random_item(MODE_WRITE);
			it.sym = syms[$urandom_range(syms.size() - 1)];
			it.len = '0;
			send_item(it);
		end
	endtask

	task automatic send_stream();
		item_t it;
		int    nbytes;
		bit    closed;
		it = random_item(MODE_HEADER);
		if ($urandom_range(3) != 0) it.byte_v = BYTE_W'($urandom_range(7));
		send_item(it);
		nbytes = $urandom_range(1, 6);
		closed = ($urandom_range(7) != 0);
		for (int k = 0; k < nbytes; k++) begin
			if ($urandom_range(9) == 0) send_item(random_item(mode_t'($urandom_range(3))));
			it = random_item(MODE_DATA);
			it.last = closed && (k == nbytes - 1);
			send_item(it);
		end
	endtask

	task automatic run_phase(input int gap, input int stall, input int n_items);
		int stop_at;
		int pick;
		gap_pct = gap;
		stall_pct = stall;
		stop_at = items_sent + n_items;
		load_code_table();
		while (items_sent < stop_at) begin
			pick = $urandom_range(15);
			if (pick == 0) begin
				load_code_table();
			end else if (pick < 3) begin
				send_item(random_item(mode_t'($urandom_range(3))));
			end else begin
				send_stream();
			end
		end
	endtask

	initial begin
		foreach (code_valid[s]) code_valid[s] = 1'b0;

		directed_rows.insert(directed_rows.size(), mk(MODE_DATA,   0,  0, 0,      8'h00, 0, 0, 0,   0));
		directed_rows.insert(directed_rows.size(), mk(MODE_DATA,   0,  0, 0,      8'hFF, 0, 0, 0,   0));
		directed_rows.insert(directed_rows.size(), mk(MODE_DATA,   0,  0, 0,      8'h5A, 0, 1, 0,   1));
		directed_rows.insert(directed_rows.size(), mk(MODE_DATA,   0,  0, 0,      8'hFF, 0, 0, 0,   0));
		directed_rows.insert(directed_rows.size(), mk(MODE_HEADER, 0,  0, 0,      8'hFF, 0, 0, 0,   0));
		directed_rows.insert(directed_rows.size(), mk(MODE_WRITE,  65, 1, 'hFFFE, 0,     0, -1, 0,  0));
		directed_rows.insert(directed_rows.size(), mk(MODE_DATA,   0,  0, 0,      8'h00, 0, 8, 65,  0));
		directed_rows.insert(directed_rows.size(), mk(MODE_DATA,   0,  0, 0,      8'h00, 1, 1, 65,  0));
		directed_rows.insert(directed_rows.size(), mk(MODE_WRITE,  255, 16, 'hFFFF, 0,   0, -1, 0,  0));
		directed_rows.insert(directed_rows.size(), mk(MODE_WRITE,  0,  16, 'hFFFF, 0,    0, -1, 0,  0));
		directed_rows.insert(directed_rows.size(), mk(MODE_WRITE,  65, 0, 0,      0,     0, -1, 0,  0));
		directed_rows.insert(directed_rows.size(), mk(MODE_HEADER, 0,  0, 0,      8'h00, 0, 0, 0,   0));
		directed_rows.insert(directed_rows.size(), mk(MODE_DATA,   0,  0, 0,      8'hFF, 0, 0, 0,   0));
		directed_rows.insert(directed_rows.size(), mk(MODE_DATA,   0,  0, 0,      8'hFF, 0, 1, 0,   0));
		directed_rows.insert(directed_rows.size(), mk(MODE_DATA,   0,  0, 0,      8'hFF, 0, -1, 0,  0));
		directed_rows.insert(directed_rows.size(), mk(MODE_CLEAR,  0,  0, 0,      0,     0, 0, 0,   0));
		directed_rows.insert(directed_rows.size(), mk(MODE_WRITE,  255, 16, 'hFFFF, 0,   0, -1, 0,  0));
		directed_rows.insert(directed_rows.size(), mk(MODE_DATA,   0,  0, 0,      8'hFF, 0, 1, 255, 0));
		directed_rows.insert(directed_rows.size(), mk(MODE_WRITE,  9,  17, 'h0001, 0,    0, -1, 0,  0));
		directed_rows.insert(directed_rows.size(), mk(MODE_WRITE,  3,  31, 0,     0,     0, -1, 0,  0));
		directed_rows.insert(directed_rows.size(), mk(MODE_DATA,   0,  0, 0,      8'h00, 0, -1, 0,  0));
		directed_rows.insert(directed_rows.size(), mk(MODE_DATA,   0,  0, 0,      8'h00, 0, -1, 0,  0));
		directed_rows.insert(directed_rows.size(), mk(MODE_DATA,   0,  0, 0,      8'h80, 1, -1, 0,  0));
		directed_rows.insert(directed_rows.size(),
			mk(MODE_HEADER, 'hAA, 31, 'hFFFF, 8'h03, 1, -1, 0, 0));
		directed_rows.insert(directed_rows.size(),
			mk(MODE_DATA,   'h55, 31, 'hFFFF, 8'hC3, 1, -1, 0, 0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k]) begin
			send_item(directed_rows[k].it, directed_rows[k].n_out,
				directed_rows[k].sym, directed_rows[k].err);
		end

		run_phase(0, 0, 80);
		run_phase(87, 0, 80);
		run_phase(0, 87, 80);
		run_phase(7, 7, 80);
		s_tvalid <= 1'b0;

		while (pending_symbols.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_symbols.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
